/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of the splitter.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/clas_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the argument splitter.
// Used by the front, queue and back modules; depends on nothing.
package clas_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Decoupling queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character classes decided by the front part
    typedef enum logic [2:0] {
        CLS_NUL,
        CLS_BLANK,
        CLS_QUOTE,
        CLS_SLASH,
        CLS_OTHER
    } clas_class_t;

    // One classified character held in the queue
    typedef struct packed {
        clas_class_t cls;
        logic [7:0]  ch;
    } clas_item_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } clas_qstat_t;

    function automatic clas_class_t clas_classify(input logic [7:0] c);
        clas_class_t r;
        if (c == CH_NUL)
            r = CLS_NUL;
        else if (c == CH_QUOTE)
            r = CLS_QUOTE;
        else if (c == CH_SLASH)
            r = CLS_SLASH;
        else if (c inside {CH_SPACE, [CH_TAB:CH_CR]})
            r = CLS_BLANK;
        else
            r = CLS_OTHER;
        return r;
    endfunction

    // Add with saturation at the top of a 16-bit count
    function automatic logic [15:0] clas_sat_add(input logic [15:0] a, input logic [8:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {8'd0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

/* rtl/core/clas_front.sv */
`timescale 1ns / 1ps
// Front part of the splitter: accepts characters and classifies them.
// Depends on clas_pkg; feeds clas_queue.
module clas_front
(
    input  logic                 push,
    input  logic [7:0]           ch,
    input  clas_pkg::clas_qstat_t qstat,
    output logic                 full,
    output logic                 q_push,
    output clas_pkg::clas_item_t q_item
);

    // Accept whenever the queue has room
    assign full   = qstat.full;
    assign q_push = push & ~qstat.full;

    // Classify the incoming character
    always_comb
    begin
        q_item.ch  = ch;
        q_item.cls = clas_pkg::clas_classify(ch);
    end

endmodule

/* rtl/core/clas_queue.sv */
`timescale 1ns / 1ps
// Short queue between the classifier and the parser.
// Depends on clas_pkg for the item and status types.
module clas_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  clas_pkg::clas_item_t  wr_item,
    input  logic                  pop,
    output clas_pkg::clas_item_t  rd_item,
    output clas_pkg::clas_qstat_t qstat
);

    clas_pkg::clas_item_t                mem [clas_pkg::QDEPTH];
    logic [clas_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [clas_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [clas_pkg::QCNT_W-1:0]         count_reg, count_next;
    logic                                do_push, do_pop;

    assign do_push = push & ~qstat.full;
    assign do_pop  = pop & ~qstat.empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_item;
    end

    // Present the oldest item and the status
    assign rd_item     = mem[rd_ptr_reg];
    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == clas_pkg::QCNT_W'(clas_pkg::QDEPTH));

endmodule

/* rtl/core/clas_back.sv */
`timescale 1ns / 1ps
// Back part of the splitter: runs the quoting and backslash rules on
// classified characters and holds one result. Depends on clas_pkg.
module clas_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  clas_pkg::clas_qstat_t qstat,
    input  clas_pkg::clas_item_t  rd_item,
    output logic                  q_pop,
    input  logic                  pop,
    output logic                  empty,
    output logic [7:0]            slash_run,
    output logic                  char_valid,
    output logic [7:0]            out_char,
    output logic                  arg_end,
    output logic                  line_end,
    output logic [15:0]           arg_total,
    output logic [15:0]           char_total
);

    logic        quoting_reg, quoting_next;
    logic        pend_reg, pend_next;
    logic        in_arg_reg, in_arg_next;
    logic [7:0]  slash_reg, slash_next;
    logic [15:0] arg_cnt_reg, arg_cnt_next;
    logic [15:0] char_cnt_reg, char_cnt_next;
    logic        valid_reg, valid_next;

    logic [7:0]  run;
    logic        cv;
    logic [7:0]  oc;
    logic        ae;
    logic        le;
    logic        done;
    logic [8:0]  add;

    // Take the next item when the result slot is free or being drained
    assign q_pop = ~qstat.empty & (~valid_reg | pop);

    // Apply the splitting rules to one character
    always_comb
    begin
        quoting_next = quoting_reg;
        pend_next    = pend_reg;
        in_arg_next  = in_arg_reg;
        slash_next   = slash_reg;
        arg_cnt_next = arg_cnt_reg;
        run  = '0;
        cv   = 1'b0;
        oc   = '0;
        ae   = 1'b0;
        le   = 1'b0;
        done = 1'b0;
        add  = '0;

        // Resolve a quote seen inside quotes
        if (pend_reg)
        begin
            pend_next    = 1'b0;
            quoting_next = 1'b0;
            if (rd_item.cls == clas_pkg::CLS_QUOTE)
            begin
                cv   = 1'b1;
                oc   = clas_pkg::CH_QUOTE;
                add  = 9'd1;
                done = 1'b1;
            end
        end

        // Skip blanks between arguments, end the line on a zero character, start a new one otherwise
        if (!done && !in_arg_reg)
        begin
            if (rd_item.cls == clas_pkg::CLS_NUL)
                le = 1'b1;
            else if (rd_item.cls != clas_pkg::CLS_BLANK)
            begin
                in_arg_next  = 1'b1;
                arg_cnt_next = clas_pkg::clas_sat_add(arg_cnt_reg, 9'd1);
            end
        end

        if (!done && in_arg_next)
        begin
            case (rd_item.cls)
                clas_pkg::CLS_SLASH:
                begin
                    // Hold the run back, keeping its parity past saturation
                    if (slash_reg < 8'd254)
                        slash_next = slash_reg + 8'd1;
                    else
                        slash_next = (slash_reg == 8'd254) ? 8'd255 : 8'd254;
                end
                clas_pkg::CLS_QUOTE:
                begin
                    run = {1'b0, slash_reg[7:1]};
                    if (slash_reg[0])
                    begin
                        cv = 1'b1;
                        oc = clas_pkg::CH_QUOTE;
                    end
                    else if (!quoting_next)
                        quoting_next = 1'b1;
                    else
                        pend_next = 1'b1;
                    slash_next = '0;
                    add = {1'b0, run} + {8'd0, cv};
                end
                clas_pkg::CLS_NUL:
                begin
                    run         = slash_reg;
                    ae          = 1'b1;
                    le          = 1'b1;
                    slash_next  = '0;
                    in_arg_next = 1'b0;
                    add         = {1'b0, run} + 9'd1;
                end
                clas_pkg::CLS_BLANK:
                begin
                    run        = slash_reg;
                    slash_next = '0;
                    add        = {1'b0, run} + 9'd1;
                    if (!quoting_next)
                    begin
                        ae          = 1'b1;
                        in_arg_next = 1'b0;
                    end
                    else
                    begin
                        cv = 1'b1;
                        oc = rd_item.ch;
                    end
                end
                default:
                begin
                    run        = slash_reg;
                    cv         = 1'b1;
                    oc         = rd_item.ch;
                    slash_next = '0;
                    add        = {1'b0, run} + 9'd1;
                end
            endcase
        end

        char_cnt_next = clas_pkg::clas_sat_add(char_cnt_reg, add);
    end

    // Hold or drop the result slot
    assign valid_next = q_pop | (valid_reg & ~pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quoting_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            in_arg_reg   <= 1'b0;
            slash_reg    <= '0;
            arg_cnt_reg  <= '0;
            char_cnt_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (q_pop)
            begin
                // Return to the idle line state after a terminator
                if (le)
                begin
                    quoting_reg  <= 1'b0;
                    pend_reg     <= 1'b0;
                    in_arg_reg   <= 1'b0;
                    slash_reg    <= '0;
                    arg_cnt_reg  <= '0;
                    char_cnt_reg <= '0;
                end
                else
                begin
                    quoting_reg  <= quoting_next;
                    pend_reg     <= pend_next;
                    in_arg_reg   <= in_arg_next;
                    slash_reg    <= slash_next;
                    arg_cnt_reg  <= arg_cnt_next;
                    char_cnt_reg <= char_cnt_next;
                end
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            slash_run  <= run;
            char_valid <= cv;
            out_char   <= oc;
            arg_end    <= ae;
            line_end   <= le;
            arg_total  <= arg_cnt_next;
            char_total <= char_cnt_next;
        end
    end

    assign empty = ~valid_reg;

endmodule

/* rtl/core/command_line_argument_splitter.sv */
`timescale 1ns / 1ps
// Command line argument splitter, top level.
// Input channel: drive ch with push high; the character is taken at a
// clock edge where full is low. A zero character ends the line.
// Result channel: while empty is low, the result ports show the oldest
// result; raise pop to take it. Every character yields one result.
// Throughput: one character per cycle while pop is held high, set by
// the state update of the parser in the back part.
// Queued characters reach the result register once the slot is free.
// A four-entry queue separates the classifier from the parser, and a
// result register sits at the output, so a stalled receiver fills the
// result slot and then the queue before full rises.
// Reset: asynchronous, active low; clears the queue, the result slot,
// the quoting state and both running totals.
// Depends on clas_pkg, clas_front, clas_queue and clas_back.
module command_line_argument_splitter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  ch,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  slash_run,
    output logic        char_valid,
    output logic [7:0]  out_char,
    output logic        arg_end,
    output logic        line_end,
    output logic [15:0] arg_total,
    output logic [15:0] char_total
);

    clas_pkg::clas_qstat_t qstat;
    clas_pkg::clas_item_t  wr_item;
    clas_pkg::clas_item_t  rd_item;
    logic                  q_push;
    logic                  q_pop;

    // Classify incoming characters
    clas_front u_front
    (
        .push   (push),
        .ch     (ch),
        .qstat  (qstat),
        .full   (full),
        .q_push (q_push),
        .q_item (wr_item)
    );

    // Decouple classifier and parser
    clas_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (wr_item),
        .pop     (q_pop),
        .rd_item (rd_item),
        .qstat   (qstat)
    );

    // Parse and hold results
    clas_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .rd_item    (rd_item),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .slash_run  (slash_run),
        .char_valid (char_valid),
        .out_char   (out_char),
        .arg_end    (arg_end),
        .line_end   (line_end),
        .arg_total  (arg_total),
        .char_total (char_total)
    );

endmodule

/* rtl/core/clas_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the argument splitter, bound to the top level.
// Depends on assert_macros.svh and command_line_argument_splitter.
`include "assert_macros.svh"

module clas_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  ch,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  slash_run,
    input  logic        char_valid,
    input  logic [7:0]  out_char,
    input  logic        arg_end,
    input  logic        line_end,
    input  logic [15:0] arg_total,
    input  logic [15:0] char_total
);

    // A result that is not taken stays on the ports
    `ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(slash_run) && $stable(out_char) && $stable(char_total))

    // An appended character never closes the argument or the line
    `ASSERT_IMPL(a_char_no_end, clk, rst_n, !empty && char_valid, !arg_end && !line_end)

    // No character means a zero character field
    `ASSERT_IMPL(a_char_zero, clk, rst_n, !empty && !char_valid, out_char == 8'h00)

    // A closed argument was counted, with its terminator
    `ASSERT_IMPL(a_end_counted, clk, rst_n, !empty && arg_end, arg_total != 16'd0 && char_total != 16'd0)

endmodule

bind command_line_argument_splitter clas_checker u_clas_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the command line argument splitter: a scoreboard
// predicts each result from the accepted characters and checks it on arrival.
// Depends on clas_pkg and command_line_argument_splitter.
module tb_top;

    localparam int OPENING_LEN  = 25;
    localparam int SEND_GOAL    = 420;
    localparam int HOLD_AFTER   = 120;
    localparam int HOLD_CYCLES  = 60;
    localparam int QUIET_FROM   = 400;
    localparam int QUIET_TO     = 550;
    localparam int REPORT_LIMIT = 10;

    // One result of the splitter, field for field
    typedef struct packed {
        logic [7:0]  slash_run;
        logic        char_valid;
        logic [7:0]  out_char;
        logic        arg_end;
        logic        line_end;
        logic [15:0] arg_total;
        logic [15:0] char_total;
    } arg_piece_t;

    class argv_scoreboard;
        bit          quoting;
        bit          quote_pending;
        bit          in_arg;
        logic [7:0]  slashes;
        logic [15:0] args;
        logic [15:0] chars;
        arg_piece_t  awaited[$];
        int          mismatches;
        int          checked;

        function new();
            clear_line();
            mismatches = 0;
            checked    = 0;
        endfunction

        function void clear_line();
            quoting       = 1'b0;
            quote_pending = 1'b0;
            in_arg        = 1'b0;
            slashes       = 8'd0;
            args          = 16'd0;
            chars         = 16'd0;
        endfunction

        function bit is_separator(logic [7:0] c);
            return c == clas_pkg::CH_SPACE ||
                   (c >= clas_pkg::CH_TAB && c <= clas_pkg::CH_CR);
        endfunction

        function logic [15:0] sat16(logic [15:0] a, int b);
            int s;
            s = int'(a) + b;
            return (s > 65535) ? 16'hFFFF : 16'(s);
        endfunction

        // Predict the result of one accepted character and queue it
        function void take_char(logic [7:0] c);
            arg_piece_t p;
            bit         done;
            p    = '0;
            done = 1'b0;

            // Resolve a quote seen inside quotes: doubled quote or quote end
            if (quote_pending) begin
                quote_pending = 1'b0;
                quoting       = 1'b0;
                if (c == clas_pkg::CH_QUOTE) begin
                    p.char_valid = 1'b1;
                    p.out_char   = clas_pkg::CH_QUOTE;
                    chars        = sat16(chars, 1);
                    done         = 1'b1;
                end
            end

            // Between arguments: skip blanks, end the line or open an argument
            if (!done && !in_arg) begin
                if (c == clas_pkg::CH_NUL)
                    p.line_end = 1'b1;
                else if (!is_separator(c)) begin
                    in_arg = 1'b1;
                    args   = sat16(args, 1);
                end
            end

            if (!done && in_arg) begin
                if (c == clas_pkg::CH_SLASH) begin
                    // Hold the run; stop at 254/255 keeping the parity exact
                    if (slashes < 8'd254)
                        slashes = slashes + 8'd1;
                    else
                        slashes = (slashes == 8'd254) ? 8'd255 : 8'd254;
                end
                else if (c == clas_pkg::CH_QUOTE) begin
                    p.slash_run = slashes >> 1;
                    if (slashes[0]) begin
                        p.char_valid = 1'b1;
                        p.out_char   = clas_pkg::CH_QUOTE;
                    end
                    else if (!quoting)
                        quoting = 1'b1;
                    else
                        quote_pending = 1'b1;
                    slashes = 8'd0;
                    chars   = sat16(chars, int'(p.slash_run) + int'(p.char_valid));
                end
                else if (c == clas_pkg::CH_NUL || (!quoting && is_separator(c))) begin
                    p.slash_run = slashes;
                    p.arg_end   = 1'b1;
                    p.line_end  = (c == clas_pkg::CH_NUL);
                    slashes     = 8'd0;
                    in_arg      = 1'b0;
                    chars       = sat16(chars, int'(p.slash_run) + 1);
                end
                else begin
                    p.slash_run  = slashes;
                    p.char_valid = 1'b1;
                    p.out_char   = c;
                    slashes      = 8'd0;
                    chars        = sat16(chars, int'(p.slash_run) + 1);
                end
            end

            p.arg_total  = args;
            p.char_total = chars;
            awaited.push_back(p);
            if (p.line_end)
                clear_line();
        endfunction

        // Compare one accepted result with the oldest prediction
        function void match_piece(arg_piece_t got);
            arg_piece_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result with no prediction: run=%0d cv=%0b ch=%02h ae=%0b le=%0b",
                             got.slash_run, got.char_valid, got.out_char, got.arg_end,
                             got.line_end);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.slash_run !== want.slash_run || got.char_valid !== want.char_valid ||
                got.out_char !== want.out_char || got.arg_end !== want.arg_end ||
                got.line_end !== want.line_end || got.arg_total !== want.arg_total ||
                got.char_total !== want.char_total) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("mismatch on result %0d", checked);
                    $display("  expected run=%0d cv=%0b ch=%02h ae=%0b le=%0b args=%0d chars=%0d",
                             want.slash_run, want.char_valid, want.out_char, want.arg_end,
                             want.line_end, want.arg_total, want.char_total);
                    $display("  actual   run=%0d cv=%0b ch=%02h ae=%0b le=%0b args=%0d chars=%0d",
                             got.slash_run, got.char_valid, got.out_char, got.arg_end,
                             got.line_end, got.arg_total, got.char_total);
                end
            end
        endfunction
    endclass

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        push  = 1'b0;
    logic [7:0]  ch    = 8'h00;
    logic        pop   = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  slash_run;
    logic        char_valid;
    logic [7:0]  out_char;
    logic        arg_end;
    logic        line_end;
    logic [15:0] arg_total;
    logic [15:0] char_total;

    argv_scoreboard sb = new();
    int chars_sent   = 0;
    int pieces_taken = 0;
    int lines_closed = 0;

    command_line_argument_splitter uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .ch         (ch),
        .empty      (empty),
        .pop        (pop),
        .slash_run  (slash_run),
        .char_valid (char_valid),
        .out_char   (out_char),
        .arg_end    (arg_end),
        .line_end   (line_end),
        .arg_total  (arg_total),
        .char_total (char_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle with a chance of 13 in 100, never inside the quiet window
    function automatic bit idles_now(int n);
        return !(n >= QUIET_FROM && n < QUIET_TO) && ($urandom_range(99) < 13);
    endfunction

    function automatic logic [7:0] pick_blank();
        logic [7:0] c;
        c = ($urandom_range(0, 2) == 0) ? clas_pkg::CH_SPACE
                                        : 8'(clas_pkg::CH_TAB + $urandom_range(0, 4));
        return c;
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == clas_pkg::CH_QUOTE || c == clas_pkg::CH_SLASH ||
               c == clas_pkg::CH_SPACE ||
               (c >= clas_pkg::CH_TAB && c <= clas_pkg::CH_CR))
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    // Offer one character and hold it until the block takes the request
    task automatic send_char(input logic [7:0] c);
        if (idles_now(chars_sent)) begin
            push <= 1'b0;
            @(posedge clk);
            while (idles_now(chars_sent))
                @(posedge clk);
        end
        push <= 1'b1;
        ch   <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.take_char(c);
        chars_sent++;
    endtask

    // One argument made of plain text, backslash runs and quoted sections
    task automatic send_argument();
        int tokens;
        int k;
        tokens = $urandom_range(1, 5);
        for (int t = 0; t < tokens; t++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_char(pick_plain());
                4, 5:
                begin
                    k = $urandom_range(1, 5);
                    repeat (k) send_char(clas_pkg::CH_SLASH);
                    if ($urandom_range(0, 1))
                        send_char(clas_pkg::CH_QUOTE);
                    else
                        send_char(pick_plain());
                end
                default:
                begin
                    send_char(clas_pkg::CH_QUOTE);
                    k = $urandom_range(0, 4);
                    repeat (k) begin
                        case ($urandom_range(0, 3))
                            0: send_char(pick_blank());
                            1:
                            begin
                                send_char(clas_pkg::CH_QUOTE);
                                send_char(clas_pkg::CH_QUOTE);
                            end
                            default: send_char(pick_plain());
                        endcase
                    end
                    // Leave a quote open now and then
                    if ($urandom_range(0, 4) != 0)
                        send_char(clas_pkg::CH_QUOTE);
                end
            endcase
        end
    endtask

    task automatic send_wellformed_line();
        int nargs;
        nargs = $urandom_range(1, 5);
        if ($urandom_range(0, 1))
            send_char(pick_blank());
        for (int a = 0; a < nargs; a++) begin
            send_argument();
            if (a < nargs - 1 || $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_char(pick_blank());
        end
        send_char(clas_pkg::CH_NUL);
    endtask

    task automatic send_noise_line();
        repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(0, 255)));
        send_char(clas_pkg::CH_NUL);
    endtask

    // Backslash run long enough to saturate the held count
    task automatic send_slash_run(input logic [7:0] tail);
        repeat (255 + $urandom_range(0, 3)) send_char(clas_pkg::CH_SLASH);
        send_char(tail);
        send_char(clas_pkg::CH_NUL);
    endtask

    // Receive results; hold off once for a long stretch to fill the block
    initial
    begin
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (pop && !empty) begin
                sb.match_piece({slash_run, char_valid, out_char, arg_end, line_end,
                                arg_total, char_total});
                pieces_taken++;
                if (line_end)
                    lines_closed++;
            end
            if (!held && pieces_taken >= HOLD_AFTER) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= !idles_now(pieces_taken);
        end
    end

    // Main stimulus
    initial
    begin
        logic [7:0] opening [OPENING_LEN];
        opening = '{
            // empty line
            clas_pkg::CH_NUL,
            // blanks skipped, short argument, even and odd runs, doubled quote,
            // pending quote then other, trailing backslashes at line end
            clas_pkg::CH_SPACE, clas_pkg::CH_TAB, 8'h61, clas_pkg::CH_CR,
            clas_pkg::CH_SLASH, clas_pkg::CH_SLASH, clas_pkg::CH_QUOTE, clas_pkg::CH_SPACE,
            clas_pkg::CH_QUOTE, clas_pkg::CH_QUOTE, clas_pkg::CH_SLASH, clas_pkg::CH_QUOTE,
            clas_pkg::CH_QUOTE, clas_pkg::CH_QUOTE, 8'h08,
            clas_pkg::CH_SLASH, clas_pkg::CH_SLASH, clas_pkg::CH_NUL,
            // edge characters, then pending quote right before line end
            8'h0E, 8'hFF, 8'h0A, clas_pkg::CH_QUOTE, clas_pkg::CH_QUOTE, clas_pkg::CH_NUL
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_char(opening[i]);

        // Mostly well-formed lines, some raw noise
        while (chars_sent < OPENING_LEN + SEND_GOAL) begin
            if ($urandom_range(0, 99) < 80)
                send_wellformed_line();
            else
                send_noise_line();
        end

        send_slash_run(clas_pkg::CH_QUOTE);
        push <= 1'b0;

        // Drain, then allow for the pipeline
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d characters over %0d lines, %0d results checked, %0d mismatches",
                 chars_sent, lines_closed, sb.checked, sb.mismatches);
        $display("included a saturated backslash run and a full-stall phase");
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
